>>> sv/style_property_table_set_macros.svh
// Assertion helpers for the RTL
`ifndef STYLE_PROPERTY_TABLE_SET_MACROS_SVH
`define STYLE_PROPERTY_TABLE_SET_MACROS_SVH

// same-cycle implication
`define SPTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPTS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/spts_pkg.sv
package spts_pkg;

    typedef enum logic [2:0] {
        ST_UPDATED  = 3'd0,
        ST_APPENDED = 3'd1,
        ST_FULL     = 3'd2,
        ST_CONSTANT = 3'd3,
        ST_INVALID  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WB
    } t_state;

    typedef enum logic [1:0] {
        CLS_SEARCH,
        CLS_CONST,
        CLS_INVALID
    } t_cls;

    // request travelling along the cell chain
    typedef struct packed {
        logic        tok;
        logic [7:0]  key;
        logic [31:0] value;
        logic        hit;
    } t_link;

endpackage

>>> sv/spts_req_if.sv
interface spts_req_if;
    logic        valid;
    logic        ready;
    logic [7:0]  property_key;
    logic [31:0] property_value;
    logic [4:0]  group_bit;

    modport source (output valid, property_key, property_value, group_bit, input ready);
    modport sink   (input valid, property_key, property_value, group_bit, output ready);
endinterface

>>> sv/spts_rsp_if.sv
interface spts_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [4:0]  entry_total;
    logic [31:0] group_mask_out;

    modport source (output valid, status, entry_total, group_mask_out, input ready);
    modport sink   (input valid, status, entry_total, group_mask_out, output ready);
endinterface

>>> sv/spts_cell.sv
module spts_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_occupied,
    input  spts_pkg::t_link i_link,
    input  logic            i_app_we,
    input  logic [7:0]      i_app_key,
    input  logic [31:0]     i_app_value,
    output spts_pkg::t_link o_link
);
    import spts_pkg::*;

    logic        r_tok;
    logic [7:0]  r_lkey;
    logic [31:0] r_lvalue;
    logic        r_lhit;
    logic [7:0]  r_key;
    logic [31:0] r_value;
    logic        match;

    // keys are unique in the table, so at most one cell ever matches
    assign match = i_link.tok && !i_link.hit && i_occupied && (r_key == i_link.key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_link.tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lkey   <= i_link.key;
        r_lvalue <= i_link.value;
        r_lhit   <= i_link.hit || match;
    end

    always_ff @(posedge i_clk) begin
        if (i_app_we) begin
            r_key   <= i_app_key;
            r_value <= i_app_value;
        end else if (match) begin
            r_value <= i_link.value;
        end
    end

    assign o_link = '{tok: r_tok, key: r_lkey, value: r_lvalue, hit: r_lhit};

endmodule

>>> sv/style_property_table_set.sv
// Channel   Dir  Payload                                      Transaction when
// i_req     in   property_key, property_value, group_bit      valid && ready
// o_rsp     out  status, entry_total, group_mask_out          valid && ready
// i_cfg_we  in   i_cfg_wdata (style_is_constant)              i_cfg_we high
// A searched request is injected into the chain, hops through every cell of the
// chain in turn, then passes a write-back step and returns to idle. Rejected
// requests go straight from idle to the write-back step.
// One request at a time; a waiting result does not block the next transaction.
// A stalled output holds the write-back step until the result register frees.
// Reset is synchronous, active low; it empties the table and clears the mask.
`include "style_property_table_set_macros.svh"

module style_property_table_set #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    spts_req_if.sink   i_req,
    spts_rsp_if.source o_rsp
);
    import spts_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state      r_state, n_state;
    t_cls        r_cls;
    logic        r_const;
    logic [CW-1:0] r_count, n_count;
    logic [31:0] r_mask, n_mask;
    logic [7:0]  r_key;
    logic [31:0] r_val;
    logic [4:0]  r_grp;
    logic        r_hit;
    logic        r_inj;
    logic        r_o_valid;
    t_status     r_status, n_status;
    logic [4:0]  r_total;
    logic [31:0] r_omask;

    logic        req_acc;
    logic        out_free;
    logic        wb_go;
    logic        do_app;
    logic        cap_hit;
    t_link       link [0:TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] tok_vec;

    assign req_acc  = i_req.valid && i_req.ready;
    assign out_free = !r_o_valid || o_rsp.ready;
    assign link[0]  = '{tok: r_inj, key: r_key, value: r_val, hit: 1'b0};

    always_comb begin
        n_state  = r_state;
        wb_go    = 1'b0;
        cap_hit  = 1'b0;
        i_req.ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    if (r_const || (i_req.property_key == 8'd0)) begin
                        n_state = S_WB;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (link[TABLE_DEPTH].tok) begin
                    cap_hit = 1'b1;
                    n_state = S_WB;
                end
            end
            S_WB: begin
                if (out_free) begin
                    wb_go   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        do_app = 1'b0;
        case (r_cls)
            CLS_CONST:   n_status = ST_CONSTANT;
            CLS_INVALID: n_status = ST_INVALID;
            default: begin
                if (r_hit) begin
                    n_status = ST_UPDATED;
                end else if (r_count == CW'(TABLE_DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_APPENDED;
                    do_app   = wb_go;
                end
            end
        endcase
        n_count = r_count + CW'(do_app);
        n_mask  = do_app ? (r_mask | (32'd1 << r_grp)) : r_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_const   <= 1'b0;
            r_count   <= '0;
            r_mask    <= '0;
            r_inj     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_mask  <= n_mask;
            r_inj   <= req_acc && !r_const && (i_req.property_key != 8'd0);
            if (i_cfg_we) begin
                r_const <= i_cfg_wdata;
            end
            if (wb_go) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_key <= i_req.property_key;
            r_val <= i_req.property_value;
            r_grp <= i_req.group_bit;
            if (r_const) begin
                r_cls <= CLS_CONST;
            end else if (i_req.property_key == 8'd0) begin
                r_cls <= CLS_INVALID;
            end else begin
                r_cls <= CLS_SEARCH;
            end
        end
        if (cap_hit) begin
            r_hit <= link[TABLE_DEPTH].hit;
        end
        if (wb_go) begin
            r_status <= n_status;
            r_total  <= 5'(n_count);
            r_omask  <= n_mask;
        end
    end

    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
        spts_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_occupied  (CW'(gi) < r_count),
            .i_link      (link[gi]),
            .i_app_we    (do_app && (r_count == CW'(gi))),
            .i_app_key   (r_key),
            .i_app_value (r_val),
            .o_link      (link[gi+1])
        );
        assign tok_vec[gi] = link[gi+1].tok;
    end

    assign o_rsp.valid          = r_o_valid;
    assign o_rsp.status         = r_status;
    assign o_rsp.entry_total    = r_total;
    assign o_rsp.group_mask_out = r_omask;

    `SPTS_ASSERT_NOW(a_tok_single, i_clk, i_rst_n, 1'b1,
        $onehot0({tok_vec, r_inj}), "more than one request in the chain")
    `SPTS_ASSERT_NOW(a_idle_chain_empty, i_clk, i_rst_n, r_state == S_IDLE,
        $countones(tok_vec) == 0, "chain busy while idle")
    `SPTS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CW'(TABLE_DEPTH), "entry count beyond table depth")
    `SPTS_ASSERT_NXT(a_append_mask, i_clk, i_rst_n, do_app,
        r_mask != 32'd0 && r_count != '0, "append left mask or count empty")

endmodule
